@@ rtl/core/psum_pkg.sv @@
// Package for the perfect-number divisor-sum block.
// Holds shared width constants and the state codes of the top level.
// No dependencies.
package psum_pkg;

    localparam int NUMBER_WIDTH_DEF = 31;
    localparam int SUM_OUT_WIDTH    = 35;
    localparam int SUM_GUARD_BITS   = 4;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ACC_I = 3'd2;
    localparam logic [2:0] ST_ACC_Q = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

endpackage

@@ rtl/core/psum_serdiv.sv @@
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on psum_pkg for the default operand width.
module psum_serdiv #(
    parameter int NUMBER_WIDTH = psum_pkg::NUMBER_WIDTH_DEF,
    parameter int DIV_WIDTH    = psum_pkg::NUMBER_WIDTH_DEF / 2 + 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [NUMBER_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]    divisor,
    output logic                    done,
    output logic [NUMBER_WIDTH-1:0] quotient,
    output logic [DIV_WIDTH-1:0]    remainder
);
    import psum_pkg::*;

    localparam int CNT_W = $clog2(NUMBER_WIDTH);

    logic [NUMBER_WIDTH-1:0] dvd_reg, dvd_next;
    logic [NUMBER_WIDTH-1:0] quot_reg, quot_next;
    logic [DIV_WIDTH-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;

    logic [NUMBER_WIDTH-1:0] src_dvd;
    logic [DIV_WIDTH-1:0]    src_rem;
    logic [DIV_WIDTH:0]      trial;
    logic [DIV_WIDTH:0]      diff;
    logic                    ge;

    always_comb begin
        src_dvd   = start ? dividend : dvd_reg;
        src_rem   = start ? '0 : rem_reg;
        trial     = {src_rem, src_dvd[NUMBER_WIDTH-1]};
        ge        = trial >= {1'b0, divisor};
        diff      = trial - {1'b0, divisor};
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start || run_reg) begin
            dvd_next  = {src_dvd[NUMBER_WIDTH-2:0], 1'b0};
            quot_next = {quot_reg[NUMBER_WIDTH-2:0], ge};
            rem_next  = ge ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
            if (start) begin
                run_next = 1'b1;
                cnt_next = CNT_W'(NUMBER_WIDTH - 1);
            end else begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/perfect_number_divisor_sum.sv @@
// Top level of the perfect-number divisor-sum block: stream ports, trial-divisor
// sequencer, sum accumulator and output register. Uses psum_pkg and psum_serdiv.
//
// For each number n the block sums the proper divisors of n by trying every
// divisor i from 2 while i*i <= n, and flags n as perfect when the sum equals n.
// Each trial divisor is run through the bit-serial divider; when i divides n,
// i is added in ACC_I and the quotient n/i in ACC_Q, which is skipped when the
// two are equal. The walk ends with the first i whose square exceeds n. Numbers
// below 2 skip the divider and give a sum of zero. One item is processed at a
// time; a new one is taken once the previous result has moved to the output
// register.
module perfect_number_divisor_sum #(
    parameter int NUMBER_WIDTH = psum_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: number in the low NUMBER_WIDTH bits, zero fill above.
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: divisor_sum [34:0], is_perfect [35], zero fill [39:36].
    output logic [((psum_pkg::SUM_OUT_WIDTH+1+7)/8)*8-1:0] m_tdata
);
    import psum_pkg::*;

    localparam int DIV_W   = NUMBER_WIDTH / 2 + 1;
    localparam int SUM_W   = NUMBER_WIDTH + SUM_GUARD_BITS;
    localparam int OUT_W   = ((SUM_OUT_WIDTH + 1 + 7) / 8) * 8;
    localparam int PAD_W   = OUT_W - SUM_OUT_WIDTH - 1;

    logic [2:0]              state_reg, state_next;
    logic [NUMBER_WIDTH-1:0] num_reg, num_next;
    logic [DIV_W-1:0]        trial_reg, trial_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    start_reg, start_next;
    logic                    mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]        mdata_reg, mdata_next;

    logic                    div_done;
    logic [NUMBER_WIDTH-1:0] div_quot;
    logic [DIV_W-1:0]        div_rem;
    logic [NUMBER_WIDTH-1:0] trial_wide;
    logic [NUMBER_WIDTH-1:0] s_num;
    logic [SUM_W+SUM_OUT_WIDTH-1:0] sum_ext;
    logic                    perfect;
    logic                    in_xfer;
    logic                    out_free;

    psum_serdiv #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .DIV_WIDTH    (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (num_reg),
        .divisor   (trial_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        s_num      = s_tdata[NUMBER_WIDTH-1:0];
        trial_wide = NUMBER_WIDTH'(trial_reg);
        sum_ext    = {{SUM_OUT_WIDTH{1'b0}}, sum_reg};
        perfect    = (num_reg >= NUMBER_WIDTH'(2)) && (sum_reg == SUM_W'(num_reg));

        state_next  = state_reg;
        num_next    = num_reg;
        trial_next  = trial_reg;
        sum_next    = sum_reg;
        start_next  = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    num_next   = s_num;
                    trial_next = DIV_W'(2);
                    if (s_num < NUMBER_WIDTH'(2)) begin
                        sum_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        sum_next   = SUM_W'(1);
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (trial_wide > div_quot) begin
                        state_next = ST_DONE;
                    end else if (div_rem == '0) begin
                        state_next = ST_ACC_I;
                    end else begin
                        trial_next = trial_reg + 1'b1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_ACC_I: begin
                sum_next = sum_reg + SUM_W'(trial_reg);
                if (div_quot != trial_wide) begin
                    state_next = ST_ACC_Q;
                end else begin
                    trial_next = trial_reg + 1'b1;
                    start_next = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_ACC_Q: begin
                sum_next   = sum_reg + SUM_W'(div_quot);
                trial_next = trial_reg + 1'b1;
                start_next = 1'b1;
                state_next = ST_DIV;
            end
            ST_DONE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {{PAD_W{1'b0}}, perfect, sum_ext[SUM_OUT_WIDTH-1:0]};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            start_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            mvalid_reg <= mvalid_next;
        end
        num_reg   <= num_next;
        trial_reg <= trial_next;
        sum_reg   <= sum_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg != ST_IDLE)
        else $error("input transfer did not start processing");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division state");

    a_trial_at_least_two: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> trial_reg >= DIV_W'(2))
        else $error("trial divisor below two during division");

    a_start_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> state_reg == ST_DIV)
        else $error("divider started outside the division state");

    a_perfect_needs_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && perfect) |-> sum_reg >= SUM_W'(6))
        else $error("perfect flag with an impossible divisor sum");

endmodule
